// File: rtl/lpci_pkg.sv
// ----------------------------------------------------------------------------
// LCD panel command interface package
// Transaction types, bus offsets, panel command codes and the ID reply table.
// ----------------------------------------------------------------------------
package lpci_pkg;

   // Bus transaction kinds
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2
   } lpci_cmd_type;

   // Request transaction payload
   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  offset;
      logic [31:0] write_data;
   } lpci_req_type;

   // Response transaction payload
   typedef struct packed {
      logic [31:0] read_data;
      logic        gram_write;
      logic [16:0] gram_address;
      logic [15:0] gram_pixel;
      logic        pixel_rejected;
      logic        te_pulse;
      logic        frame_request;
      logic        display_visible;
   } lpci_rsp_type;

   // Bus register offsets with special handling
   localparam logic [7:0] OFS_COMMAND      = 8'h04;
   localparam logic [7:0] OFS_ID_CTRL      = 8'h10;
   localparam logic [7:0] OFS_ID_REPLY     = 8'h14;
   localparam logic [7:0] OFS_STATUS       = 8'h1c;
   localparam logic [7:0] OFS_DATA         = 8'h40;
   localparam logic [7:0] OFS_FRAME_ENGINE = 8'h70;
   localparam logic [7:0] OFS_FRAME_INPUT  = 8'h80;
   localparam logic [7:0] OFS_FRAME_STATUS = 8'h8c;

   // Fixed status word returned on the status register
   localparam logic [31:0] STATUS_VALUE = 32'd3;

   // Panel command codes
   localparam logic [7:0] PCMD_READ_ID   = 8'h04;
   localparam logic [7:0] PCMD_SLEEP_IN  = 8'h10;
   localparam logic [7:0] PCMD_SLEEP_OUT = 8'h11;
   localparam logic [7:0] PCMD_DISP_OFF  = 8'h28;
   localparam logic [7:0] PCMD_DISP_ON   = 8'h29;
   localparam logic [7:0] PCMD_COL_ADDR  = 8'h2a;
   localparam logic [7:0] PCMD_PAGE_ADDR = 8'h2b;
   localparam logic [7:0] PCMD_MEM_WRITE = 8'h2c;
   localparam logic [7:0] PCMD_TE_OFF    = 8'h34;
   localparam logic [7:0] PCMD_TE_ON     = 8'h35;

   // Length of the read-ID reply in bytes
   localparam logic [2:0] ID_REPLY_LENGTH = 3'd4;

   // Reset value of the tearing-effect period
   localparam logic [23:0] TE_PERIOD_RESET = 24'd16667;

   // Read-ID reply bytes
   function automatic logic [7:0] id_reply_byte(input logic [1:0] position);
      logic [7:0] value;
      case (position)
         2'd0:    value = 8'h00;
         2'd1:    value = 8'h38;
         2'd2:    value = 8'hb3;
         default: value = 8'h71;
      endcase
      return value;
   endfunction

endpackage

// File: rtl/lcd_panel_command_interface_top.sv
// ----------------------------------------------------------------------------
// LCD panel command interface top level
// Input register, command core and response register.
// ----------------------------------------------------------------------------
// One request transaction (bus read, bus write or time tick) is accepted per
// clock when not stalled and gives exactly one response transaction, offered
// on the response port from the output register: the request lands in an
// input register, the core decodes it and updates its state as the response
// is loaded into the output register, and the response is held there until
// taken. Throughput is one transaction per cycle, set by the single
// decode-and-update path of the core; a stalled response holds the input
// register, which then stalls the request side. No clearing pass runs after
// reset. The user must write the tearing-effect period through the csr port
// only while the block is idle; the block itself does not enforce this.
module lcd_panel_command_interface_top
   import lpci_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = 320,
   parameter int DISPLAY_HEIGHT = 240
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lpci_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lpci_rsp_type rsp_data,
   input  logic         csr_write_enable,
   input  logic [23:0]  csr_write_data
);

   logic         in_valid_ff;
   lpci_req_type in_data_ff;
   logic         rsp_valid_ff;
   lpci_rsp_type rsp_data_ff;
   lpci_rsp_type core_rsp;
   logic         advance;
   logic         step;

   // Pipeline moves when the response register is free or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   lpci_core #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .req              (in_data_ff),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp              (core_rsp)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= core_rsp;
      end
   end

`ifndef SYNTH
   // Request side stalls only with a transaction waiting in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with empty input register");

   // A waiting transaction moves to the response register when not stalled
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_stall |=> rsp_valid)
      else $error("transaction lost between input and response registers");

   // A stalled input transaction keeps the response register occupied
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid && rsp_stall |=> in_valid_ff && rsp_valid)
      else $error("pipeline dropped a stalled transaction");
`endif

endmodule

// File: rtl/lpci_core.sv
// ----------------------------------------------------------------------------
// LCD panel command interface core
// Bus register store, panel command decode, window and cursor logic and the
// tearing-effect timer. One transaction is processed per step.
// ----------------------------------------------------------------------------
module lpci_core
   import lpci_pkg::*;
#(
   parameter int DISPLAY_WIDTH  = 320,
   parameter int DISPLAY_HEIGHT = 240
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  lpci_req_type req,
   input  logic         csr_write_enable,
   input  logic [23:0]  csr_write_data,
   output lpci_rsp_type rsp
);

   localparam int          SLOT_COUNT   = 15;
   localparam int          SLOT_BITS    = $clog2(SLOT_COUNT);
   localparam logic [16:0] COL_LIMIT    = 17'(DISPLAY_WIDTH);
   localparam logic [16:0] ROW_LIMIT    = 17'(DISPLAY_HEIGHT);
   localparam logic [16:0] ROW_STRIDE   = 17'(DISPLAY_WIDTH);
   localparam logic [15:0] COL_END_INIT = 16'(DISPLAY_WIDTH - 1);
   localparam logic [15:0] ROW_END_INIT = 16'(DISPLAY_HEIGHT - 1);

   localparam logic [SLOT_BITS-1:0] SLOT_ID_REPLY     = SLOT_BITS'(4);
   localparam logic [SLOT_BITS-1:0] SLOT_FRAME_ENGINE = SLOT_BITS'(8);
   localparam logic [SLOT_BITS-1:0] SLOT_FRAME_INPUT  = SLOT_BITS'(12);

   typedef struct packed {
      logic                 hit;
      logic [SLOT_BITS-1:0] slot;
   } lpci_slot_type;

   // Map a readable bus offset onto its storage slot
   function automatic lpci_slot_type decode_slot(input logic [7:0] offset);
      lpci_slot_type result;
      result.hit = 1'b1;
      unique case (offset)
         8'h00:   result.slot = SLOT_BITS'(0);
         8'h04:   result.slot = SLOT_BITS'(1);
         8'h0c:   result.slot = SLOT_BITS'(2);
         8'h10:   result.slot = SLOT_BITS'(3);
         8'h14:   result.slot = SLOT_BITS'(4);
         8'h18:   result.slot = SLOT_BITS'(5);
         8'h20:   result.slot = SLOT_BITS'(6);
         8'h40:   result.slot = SLOT_BITS'(7);
         8'h70:   result.slot = SLOT_BITS'(8);
         8'h74:   result.slot = SLOT_BITS'(9);
         8'h78:   result.slot = SLOT_BITS'(10);
         8'h7c:   result.slot = SLOT_BITS'(11);
         8'h80:   result.slot = SLOT_BITS'(12);
         8'h84:   result.slot = SLOT_BITS'(13);
         8'h88:   result.slot = SLOT_BITS'(14);
         default: begin
            result.hit  = 1'b0;
            result.slot = '0;
         end
      endcase
      return result;
   endfunction

   // State
   logic [31:0] store_ff [SLOT_COUNT];
   logic [23:0] te_period_ff;
   logic [7:0]  last_cmd_ff,   last_cmd_in;
   logic [7:0]  param_count_ff, param_count_in;
   logic [15:0] col_start_ff,  col_start_in;
   logic [15:0] col_end_ff,    col_end_in;
   logic [15:0] page_start_ff, page_start_in;
   logic [15:0] page_end_ff,   page_end_in;
   logic [15:0] cursor_col_ff, cursor_col_in;
   logic [15:0] cursor_row_ff, cursor_row_in;
   logic        sleeping_ff,   sleeping_in;
   logic        disp_en_ff,    disp_en_in;
   logic        te_en_ff,      te_en_in;
   logic [23:0] te_count_ff,   te_count_in;
   logic [2:0]  reply_pos_ff,  reply_pos_in;
   logic [2:0]  reply_len_ff,  reply_len_in;

   lpci_slot_type slot_sel;
   logic          store_wr;
   logic          id_load;
   logic [31:0]   id_value;
   logic          window_ok;
   logic          cursor_ok;
   logic [16:0]   pixel_addr;
   logic [15:0]   col_inc;
   logic [15:0]   row_inc;
   logic [23:0]   te_inc;
   logic [7:0]    cmd_byte;

   assign slot_sel = decode_slot(req.offset);
   assign cmd_byte = req.write_data[7:0];

   // Window checks against the current limits
   assign window_ok = (col_start_ff <= col_end_ff) && (page_start_ff <= page_end_ff) &&
                      ({1'b0, col_end_ff} < COL_LIMIT) && ({1'b0, page_end_ff} < ROW_LIMIT);
   assign cursor_ok = (cursor_col_ff >= col_start_ff) && (cursor_col_ff <= col_end_ff) &&
                      (cursor_row_ff >= page_start_ff) && (cursor_row_ff <= page_end_ff);

   // Pixel index, kept to 17 bits
   assign pixel_addr = 17'({1'b0, cursor_row_ff} * ROW_STRIDE + {1'b0, cursor_col_ff});
   assign col_inc    = cursor_col_ff + 16'd1;
   assign row_inc    = cursor_row_ff + 16'd1;
   assign te_inc     = te_count_ff + 24'd1;
   assign id_value   = {23'd0, id_reply_byte(reply_pos_ff[1:0]), 1'b0};

   // Decode one transaction and form next state and response
   always_comb begin
      last_cmd_in    = last_cmd_ff;
      param_count_in = param_count_ff;
      col_start_in   = col_start_ff;
      col_end_in     = col_end_ff;
      page_start_in  = page_start_ff;
      page_end_in    = page_end_ff;
      cursor_col_in  = cursor_col_ff;
      cursor_row_in  = cursor_row_ff;
      sleeping_in    = sleeping_ff;
      disp_en_in     = disp_en_ff;
      te_en_in       = te_en_ff;
      te_count_in    = te_count_ff;
      reply_pos_in   = reply_pos_ff;
      reply_len_in   = reply_len_ff;
      store_wr       = 1'b0;
      id_load        = 1'b0;
      rsp            = '0;

      unique case (req.command)
         CMD_READ: begin
            if (req.offset == OFS_STATUS) begin
               rsp.read_data = STATUS_VALUE;
            end else if (req.offset != OFS_FRAME_STATUS && slot_sel.hit) begin
               rsp.read_data = store_ff[slot_sel.slot];
            end
         end
         CMD_WRITE: begin
            store_wr = slot_sel.hit;
            if (req.offset == OFS_COMMAND) begin
               // Panel command: latch and decode the low byte
               last_cmd_in    = cmd_byte;
               param_count_in = 8'd0;
               unique case (cmd_byte)
                  PCMD_READ_ID: begin
                     reply_len_in = ID_REPLY_LENGTH;
                     reply_pos_in = 3'd0;
                  end
                  PCMD_SLEEP_IN: begin
                     sleeping_in = 1'b1;
                     te_count_in = 24'd0;
                  end
                  PCMD_SLEEP_OUT: begin
                     sleeping_in = 1'b0;
                     te_count_in = 24'd0;
                  end
                  PCMD_DISP_OFF: disp_en_in = 1'b0;
                  PCMD_DISP_ON:  disp_en_in = 1'b1;
                  PCMD_TE_OFF: begin
                     te_en_in    = 1'b0;
                     te_count_in = 24'd0;
                  end
                  PCMD_TE_ON: begin
                     te_en_in    = 1'b1;
                     te_count_in = 24'd0;
                  end
                  PCMD_MEM_WRITE: begin
                     cursor_col_in     = col_start_ff;
                     cursor_row_in     = page_start_ff;
                     rsp.frame_request = store_ff[SLOT_FRAME_ENGINE][0] &&
                                         store_ff[SLOT_FRAME_INPUT][0] && window_ok;
                  end
                  default: ;
               endcase
            end else if (req.offset == OFS_DATA) begin
               if (last_cmd_ff == PCMD_MEM_WRITE) begin
                  // Pixel data: store at cursor and walk the window, or reject it outside
                  if (!window_ok || !cursor_ok) begin
                     rsp.pixel_rejected = 1'b1;
                  end else begin
                     rsp.gram_write   = 1'b1;
                     rsp.gram_address = pixel_addr;
                     rsp.gram_pixel   = req.write_data[15:0];
                     if (col_inc > col_end_ff) begin
                        cursor_col_in = col_start_ff;
                        cursor_row_in = (row_inc > page_end_ff) ? page_start_ff : row_inc;
                     end else begin
                        cursor_col_in = col_inc;
                     end
                  end
               end else begin
                  // Window parameters: first two bytes start, next two end
                  if (param_count_ff < 8'd4) begin
                     if (last_cmd_ff == PCMD_COL_ADDR) begin
                        if (param_count_ff < 8'd2) begin
                           col_start_in = {col_start_ff[7:0], req.write_data[7:0]};
                        end else begin
                           col_end_in = {col_end_ff[7:0], req.write_data[7:0]};
                        end
                     end else if (last_cmd_ff == PCMD_PAGE_ADDR) begin
                        if (param_count_ff < 8'd2) begin
                           page_start_in = {page_start_ff[7:0], req.write_data[7:0]};
                        end else begin
                           page_end_in = {page_end_ff[7:0], req.write_data[7:0]};
                        end
                     end
                  end
                  if (param_count_ff != 8'hff) begin
                     param_count_in = param_count_ff + 8'd1;
                  end
               end
            end else if (req.offset == OFS_ID_CTRL) begin
               // ID reply fetch on a zero write
               if (req.write_data == 32'd0) begin
                  id_load = 1'b1;
                  if (reply_pos_ff < reply_len_ff) begin
                     reply_pos_in = reply_pos_ff + 3'd1;
                  end
               end
            end
         end
         CMD_TICK: begin
            // Tearing-effect timer
            if (te_en_ff && !sleeping_ff) begin
               if (te_inc >= te_period_ff) begin
                  rsp.te_pulse = 1'b1;
                  te_count_in  = 24'd0;
               end else begin
                  te_count_in = te_inc;
               end
            end
         end
         default: ;
      endcase

      rsp.display_visible = disp_en_in && !sleeping_in;
   end

   // Bus register store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else if (step) begin
         if (store_wr) begin
            store_ff[slot_sel.slot] <= req.write_data;
         end
         if (id_load) begin
            store_ff[SLOT_ID_REPLY] <= (reply_pos_ff < reply_len_ff) ? id_value : 32'd0;
         end
      end
   end

   // Panel state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cmd_ff    <= 8'd0;
         param_count_ff <= 8'd0;
         col_start_ff   <= 16'd0;
         col_end_ff     <= COL_END_INIT;
         page_start_ff  <= 16'd0;
         page_end_ff    <= ROW_END_INIT;
         cursor_col_ff  <= 16'd0;
         cursor_row_ff  <= 16'd0;
         sleeping_ff    <= 1'b1;
         disp_en_ff     <= 1'b0;
         te_en_ff       <= 1'b0;
         te_count_ff    <= 24'd0;
         reply_pos_ff   <= 3'd0;
         reply_len_ff   <= 3'd0;
      end else if (step) begin
         last_cmd_ff    <= last_cmd_in;
         param_count_ff <= param_count_in;
         col_start_ff   <= col_start_in;
         col_end_ff     <= col_end_in;
         page_start_ff  <= page_start_in;
         page_end_ff    <= page_end_in;
         cursor_col_ff  <= cursor_col_in;
         cursor_row_ff  <= cursor_row_in;
         sleeping_ff    <= sleeping_in;
         disp_en_ff     <= disp_en_in;
         te_en_ff       <= te_en_in;
         te_count_ff    <= te_count_in;
         reply_pos_ff   <= reply_pos_in;
         reply_len_ff   <= reply_len_in;
      end
   end

   // Tearing-effect period register
   always_ff @(posedge clock) begin
      if (reset) begin
         te_period_ff <= TE_PERIOD_RESET;
      end else if (csr_write_enable) begin
         te_period_ff <= csr_write_data;
      end
   end

`ifndef SYNTH
   // A pixel is either stored or dropped, never both
   assert property (@(posedge clock) disable iff (reset)
      step |-> !(rsp.gram_write && rsp.pixel_rejected))
      else $error("pixel both stored and rejected");

   // The tearing-effect counter restarts after each pulse
   assert property (@(posedge clock) disable iff (reset)
      step && rsp.te_pulse |=> te_count_ff == 24'd0)
      else $error("te counter not restarted after pulse");

   // A frame request leaves the cursor at the window origin
   assert property (@(posedge clock) disable iff (reset)
      step && rsp.frame_request |=>
         cursor_col_ff == col_start_ff && cursor_row_ff == page_start_ff)
      else $error("cursor not at window origin after memory write command");
`endif

endmodule
